FILE: design/sltab_pkg.sv
`default_nettype none
package sltab_pkg;

  localparam int DEFAULT_CAPACITY = 256;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 9;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GET         = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOCATE      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PREDECESSOR = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SUCCESSOR   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CLEAR       = 3'd6;
  localparam logic [KIND_W-1:0] KIND_APPEND      = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

endpackage
`default_nettype wire

FILE: design/sequential_list_table_top.sv
`default_nettype none
// Channel   Direction  Handshake            Payload
// in        input      in_valid, in_stall   kind, position, value
// out       output     out_valid, out_stall status, out_value, found_position, list_length
//
// One item is worked at a time. Insert and delete move the entries behind the position,
// one store entry read and one written per cycle; get reads one entry and clear needs none.
// Locate, predecessor, successor and append walk the store one entry per cycle, up to
// the list length. The single store read port sets this pace.
// Reset empties the list at once; the store itself is not cleared. in_stall is high
// while an item is at work; a stalled result holds while the next item is accepted.
module sequential_list_table_top #(
  parameter int CAPACITY = sltab_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [sltab_pkg::KIND_W-1:0]    kind,
  input  wire logic [sltab_pkg::POS_W-1:0]     position,
  input  wire logic signed [sltab_pkg::VALUE_W-1:0] value,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [sltab_pkg::STATUS_W-1:0]       status,
  output logic signed [sltab_pkg::VALUE_W-1:0] out_value,
  output logic [sltab_pkg::POS_W-1:0]          found_position,
  output logic [sltab_pkg::POS_W-1:0]          list_length
);
  import sltab_pkg::*;

  // Address width, count width (holds CAPACITY itself) and a compare width that
  // covers both the count and the position port with one spare bit.
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_GOT, S_SHR, S_SHL, S_SCAN, S_DONE
  } state_t;

  state_t              state;
  logic [CW-1:0]       cnt;
  logic [KIND_W-1:0]   kind_r;
  logic [EW-1:0]       pos_r;
  logic [VALUE_W-1:0]  val_r;
  logic [AW-1:0]       ridx;
  logic [AW-1:0]       didx;
  logic [CW-1:0]       rem;
  logic                rv;
  logic                take_next;
  logic [VALUE_W-1:0]  prev;
  logic [VALUE_W-1:0]  res;
  logic [CW-1:0]       fpos;
  logic [STATUS_W-1:0] st;

  logic                rd_en;
  logic [AW-1:0]       raddr;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [VALUE_W-1:0]  wdata;
  logic [VALUE_W-1:0]  rdata;

  logic [EW-1:0] posx;
  logic [EW-1:0] cntx;
  logic          accept;
  logic          is_full;
  logic          hit;
  logic          scan_end;
  logic          succ_ok;

  assign posx     = EW'(position);
  assign cntx     = EW'(cnt);
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign is_full  = (cntx == EW'(CAPACITY));
  assign hit      = rv && (rdata == val_r);
  // Nothing left to read and nothing in flight: the scan found no match.
  assign scan_end = !rv && (rem == '0);
  // A successor match needs a following entry inside the list.
  assign succ_ok  = ((CW + 1)'(didx) + (CW + 1)'(1)) < (CW + 1)'(cnt);

  // Store port control. Reads run one entry ahead of the write-back, so the
  // shifts never read an entry that is still to be written.
  always_comb begin
    rd_en = 1'b0;
    raddr = ridx;
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    case (state)
      S_FETCH: begin
        rd_en = 1'b1;
        raddr = AW'(pos_r - EW'(1));
      end
      S_SHR: begin
        rd_en = (rem != '0);
        if (rv) begin
          we    = 1'b1;
          waddr = didx + AW'(1);
        end else if (rem == '0) begin
          we    = 1'b1;
          waddr = AW'(pos_r - EW'(1));
          wdata = val_r;
        end
      end
      S_SHL: begin
        rd_en = (rem != '0);
        if (rv) begin
          we    = 1'b1;
          waddr = didx - AW'(1);
        end
      end
      S_SCAN: begin
        rd_en = (rem != '0);
        if (scan_end && kind_r == KIND_APPEND && cntx != EW'(CAPACITY)) begin
          we    = 1'b1;
          waddr = AW'(cnt);
          wdata = val_r;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  sltab_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rv        <= 1'b0;
      take_next <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rv <= rd_en;
      if (rd_en) begin
        didx <= ridx;
      end
      // In the done state the result register is handled below.
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            kind_r    <= kind;
            pos_r     <= posx;
            val_r     <= value;
            res       <= '0;
            fpos      <= '0;
            st        <= ST_OK;
            take_next <= 1'b0;
            case (kind)
              KIND_INSERT: begin
                if (posx == '0 || posx > cntx + EW'(1)) begin
                  st    <= ST_RANGE;
                  state <= S_DONE;
                end else if (is_full) begin
                  st    <= ST_FULL;
                  state <= S_DONE;
                end else begin
                  rem   <= CW'(cntx - posx + EW'(1));
                  ridx  <= AW'(cntx - EW'(1));
                  state <= S_SHR;
                end
              end
              KIND_DELETE, KIND_GET: begin
                if (posx == '0 || posx > cntx) begin
                  st    <= ST_RANGE;
                  state <= S_DONE;
                end else begin
                  state <= S_FETCH;
                end
              end
              KIND_CLEAR: begin
                cnt   <= '0;
                state <= S_DONE;
              end
              default: begin
                rem   <= cnt;
                ridx  <= '0;
                state <= S_SCAN;
              end
            endcase
          end
        end
        S_FETCH: begin
          state <= S_GOT;
        end
        S_GOT: begin
          res <= rdata;
          if (kind_r == KIND_GET) begin
            state <= S_DONE;
          end else begin
            rem   <= CW'(cntx - pos_r);
            ridx  <= AW'(pos_r);
            state <= S_SHL;
          end
        end
        S_SHR: begin
          if (rem != '0) begin
            rem  <= rem - CW'(1);
            ridx <= ridx - AW'(1);
          end else if (!rv) begin
            cnt   <= cnt + CW'(1);
            state <= S_DONE;
          end
        end
        S_SHL: begin
          if (rem != '0) begin
            rem  <= rem - CW'(1);
            ridx <= ridx + AW'(1);
          end else if (!rv) begin
            cnt   <= cnt - CW'(1);
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          if (rem != '0) begin
            rem  <= rem - CW'(1);
            ridx <= ridx + AW'(1);
          end
          if (rv) begin
            prev <= rdata;
          end
          case (kind_r)
            KIND_PREDECESSOR: begin
              if (hit && didx != '0) begin
                res   <= prev;
                state <= S_DONE;
              end else if (scan_end) begin
                st    <= ST_MISSING;
                state <= S_DONE;
              end
            end
            KIND_SUCCESSOR: begin
              // The read of the following entry was issued in the match cycle.
              if (rv && take_next) begin
                res   <= rdata;
                state <= S_DONE;
              end else if (hit && succ_ok) begin
                take_next <= 1'b1;
              end else if (scan_end) begin
                st    <= ST_MISSING;
                state <= S_DONE;
              end
            end
            KIND_APPEND: begin
              if (hit) begin
                fpos  <= CW'(didx) + CW'(1);
                state <= S_DONE;
              end else if (scan_end) begin
                if (is_full) begin
                  st <= ST_FULL;
                end else begin
                  cnt  <= cnt + CW'(1);
                  fpos <= cnt + CW'(1);
                end
                state <= S_DONE;
              end
            end
            default: begin
              if (hit) begin
                fpos  <= CW'(didx) + CW'(1);
                state <= S_DONE;
              end else if (scan_end) begin
                st    <= ST_MISSING;
                state <= S_DONE;
              end
            end
          endcase
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            status         <= st;
            out_value      <= res;
            found_position <= POS_W'(fpos);
            list_length    <= POS_W'(cnt);
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    EW'(cnt) <= EW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE || state == S_FETCH || state == S_GOT) |-> !we)
    else $error("store written outside a shift or append");

  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    rv |-> $past(rd_en))
    else $error("read data flagged without a read");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && st == ST_FULL) |-> is_full)
    else $error("full status with room left");
`endif

endmodule
`default_nettype wire

FILE: design/sltab_ram.sv
`default_nettype none
module sltab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
